// ----- src/ej2d_pkg.sv -----
// Shared types and fixed constants for the 2D element Jacobian pipeline.
// No dependencies; used by ej2d_entry, element_jacobian_2d and the testbench.
`default_nettype none

package ej2d_pkg;

  // determinant is 64 bits at every coordinate width; Q32.32 for Q16.16
  localparam int unsigned DET_WIDTH = 64;

  // per-stage load strobes handed to each entry lane
  typedef struct packed {
    logic en_mul;   // load product registers
    logic en_sum;   // load rounded, saturated entry
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ----- src/ej2d_entry.sv -----
// One Jacobian entry lane: two weighted differences, exact sum, round, saturate.
// Two register stages (products, entry). Depends on ej2d_pkg.
`default_nettype none

module ej2d_entry #(
  parameter int COORD_WIDTH     = 32,
  parameter int LOCAL_FRAC_BITS = 14
) (
  input  wire                              clk,
  input  wire ej2d_pkg::pipe_ctl_t         ctl,
  input  wire logic signed [LOCAL_FRAC_BITS+2:0] fa,
  input  wire logic signed [COORD_WIDTH:0]       da,
  input  wire logic signed [LOCAL_FRAC_BITS+2:0] fb,
  input  wire logic signed [COORD_WIDTH:0]       db,
  output logic signed [COORD_WIDTH-1:0]    entry_r,
  output logic                             ovf_r
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int WW = LOCAL_FRAC_BITS + 3;
  localparam int PW = DW + WW;
  localparam int SW = PW + 1;
  localparam int SH = LOCAL_FRAC_BITS + 2;
  localparam int QW = SW - SH;   // width after the divide by 4*one
  localparam logic signed [SW-1:0] RND = SW'(1) << (LOCAL_FRAC_BITS + 1);
  localparam logic signed [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [PW-1:0] pa_r, pb_r, pa_nxt, pb_nxt;
  logic signed [SW-1:0] sum;
  logic signed [QW-1:0] quo;
  logic                 fits;
  logic signed [COORD_WIDTH-1:0] entry_nxt;
  logic                 ovf_nxt;

  always_comb begin
    pa_nxt = PW'(fa) * PW'(da);
    pb_nxt = PW'(fb) * PW'(db);
  end

  always_comb begin
    sum  = SW'(pa_r) + SW'(pb_r) + RND;
    quo  = sum[SW-1:SH];
    // in range when every bit above the entry's sign bit matches it
    fits = (&quo[QW-1:COORD_WIDTH-1]) | ~(|quo[QW-1:COORD_WIDTH-1]);
    if (fits) begin
      entry_nxt = quo[COORD_WIDTH-1:0];
    end else if (quo[QW-1]) begin
      entry_nxt = MINV;
    end else begin
      entry_nxt = MAXV;
    end
    ovf_nxt = ~fits;
  end

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
    if (ctl.en_sum) begin
      entry_r <= entry_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/element_jacobian_2d.sv -----
// Top level: 2x2 Jacobian and determinant of a bilinear 2D element, five stages.
// Depends on ej2d_pkg and ej2d_entry.
`default_nettype none
//
//  channel | dir | tdata                                      | tuser
//  --------+-----+--------------------------------------------+------
//  in_     | in  | x0..x3, y0..y3, xi, eta                    | kind
//  out_    | out | dx_dxi, dx_deta, dy_dxi, dy_deta, det, ovf | -
//
//  One word per cycle in and out while out_tready holds; stages in order: diffs,
//  entry products, entry round/saturate, determinant products, determinant sum.
//  The two multiplier ranks set the stage depth.
//  Reset clears only the stage valid bits; payload registers are not reset.
//  Each stage loads when it is empty or the stage after it moves, so a stall
//  at the output fills bubbles first and in_tready drops only when all five
//  stages hold words.

module element_jacobian_2d #(
  parameter int COORD_WIDTH     = 32,
  parameter int LOCAL_FRAC_BITS = 14
) (
  input  wire clk,
  input  wire rst_n,
  input  wire in_tvalid,
  output logic in_tready,
  // x0, x1, x2, x3, y0, y1, y2, y3, local_xi, local_eta (low to high), zero pad
  input  wire [((8*COORD_WIDTH+2*(LOCAL_FRAC_BITS+2)+7)/8)*8-1:0] in_tdata,
  // kind
  input  wire in_tuser,
  output logic out_tvalid,
  input  wire out_tready,
  // dx_dxi, dx_deta, dy_dxi, dy_deta, determinant, overflow (low to high), zero pad
  output logic [((4*COORD_WIDTH+ej2d_pkg::DET_WIDTH+1+7)/8)*8-1:0] out_tdata
);

  localparam int CW     = COORD_WIDTH;
  localparam int LW     = LOCAL_FRAC_BITS + 2;
  localparam int DW     = CW + 1;
  localparam int WW     = LOCAL_FRAC_BITS + 3;
  localparam int DETW   = ej2d_pkg::DET_WIDTH;
  localparam int OUT_B  = 4*CW + DETW + 1;
  localparam int OUT_TW = ((OUT_B + 7) / 8) * 8;
  localparam int PW     = 2*CW;
  localparam int EW     = (2*CW + 1 > DETW) ? 2*CW + 1 : DETW;
  localparam logic signed [WW-1:0]   ONE  = WW'(1) << LOCAL_FRAC_BITS;
  localparam logic signed [DETW-1:0] DMAX = {1'b0, {(DETW-1){1'b1}}};
  localparam logic signed [DETW-1:0] DMIN = {1'b1, {(DETW-1){1'b0}}};

  // stage valid bits and load enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  always_comb begin
    en5 = ~v5_r | out_tready;
    en4 = ~v4_r | en5;
    en3 = ~v3_r | en4;
    en2 = ~v2_r | en3;
    en1 = ~v1_r | en2;
  end

  assign in_tready  = en1;
  assign out_tvalid = v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // ---- stage 1: coordinate differences and shape-function weights ----
  logic signed [CW-1:0] x0, x1, x2, x3, y0, y1, y2, y3;
  logic signed [LW-1:0] xi, eta;
  logic signed [DW-1:0] dxa_nxt, dxb_nxt, dxc_nxt, dxd_nxt;
  logic signed [DW-1:0] dya_nxt, dyb_nxt, dyc_nxt, dyd_nxt;
  logic signed [DW-1:0] dxa_r, dxb_r, dxc_r, dxd_r, dya_r, dyb_r, dyc_r, dyd_r;
  logic signed [WW-1:0] wme_nxt, wpe_nxt, wmx_nxt, wpx_nxt;
  logic signed [WW-1:0] wme_r, wpe_r, wmx_r, wpx_r;

  always_comb begin
    x0  = in_tdata[0*CW +: CW];
    x1  = in_tdata[1*CW +: CW];
    x2  = in_tdata[2*CW +: CW];
    // collapsed triangle: node 3 sits on node 2
    x3  = in_tuser ? in_tdata[3*CW +: CW] : in_tdata[2*CW +: CW];
    y0  = in_tdata[4*CW +: CW];
    y1  = in_tdata[5*CW +: CW];
    y2  = in_tdata[6*CW +: CW];
    y3  = in_tuser ? in_tdata[7*CW +: CW] : in_tdata[6*CW +: CW];
    xi  = in_tdata[8*CW +: LW];
    eta = in_tdata[8*CW+LW +: LW];

    dxa_nxt = DW'(x1) - DW'(x0);
    dxb_nxt = DW'(x2) - DW'(x3);
    dxc_nxt = DW'(x3) - DW'(x0);
    dxd_nxt = DW'(x2) - DW'(x1);
    dya_nxt = DW'(y1) - DW'(y0);
    dyb_nxt = DW'(y2) - DW'(y3);
    dyc_nxt = DW'(y3) - DW'(y0);
    dyd_nxt = DW'(y2) - DW'(y1);

    wme_nxt = ONE - WW'(eta);
    wpe_nxt = ONE + WW'(eta);
    wmx_nxt = ONE - WW'(xi);
    wpx_nxt = ONE + WW'(xi);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      dxa_r <= dxa_nxt;
      dxb_r <= dxb_nxt;
      dxc_r <= dxc_nxt;
      dxd_r <= dxd_nxt;
      dya_r <= dya_nxt;
      dyb_r <= dyb_nxt;
      dyc_r <= dyc_nxt;
      dyd_r <= dyd_nxt;
      wme_r <= wme_nxt;
      wpe_r <= wpe_nxt;
      wmx_r <= wmx_nxt;
      wpx_r <= wpx_nxt;
    end
  end

  // ---- stages 2 and 3: four entry lanes ----
  ej2d_pkg::pipe_ctl_t lane_ctl;
  logic signed [CW-1:0] a_e, b_e, c_e, d_e;
  logic                 a_ovf, b_ovf, c_ovf, d_ovf;

  always_comb begin
    lane_ctl.en_mul = en2;
    lane_ctl.en_sum = en3;
  end

  ej2d_entry #(.COORD_WIDTH(CW), .LOCAL_FRAC_BITS(LOCAL_FRAC_BITS)) u_dx_dxi (
    .clk(clk), .ctl(lane_ctl),
    .fa(wme_r), .da(dxa_r), .fb(wpe_r), .db(dxb_r),
    .entry_r(a_e), .ovf_r(a_ovf)
  );

  ej2d_entry #(.COORD_WIDTH(CW), .LOCAL_FRAC_BITS(LOCAL_FRAC_BITS)) u_dx_deta (
    .clk(clk), .ctl(lane_ctl),
    .fa(wmx_r), .da(dxc_r), .fb(wpx_r), .db(dxd_r),
    .entry_r(b_e), .ovf_r(b_ovf)
  );

  ej2d_entry #(.COORD_WIDTH(CW), .LOCAL_FRAC_BITS(LOCAL_FRAC_BITS)) u_dy_dxi (
    .clk(clk), .ctl(lane_ctl),
    .fa(wme_r), .da(dya_r), .fb(wpe_r), .db(dyb_r),
    .entry_r(c_e), .ovf_r(c_ovf)
  );

  ej2d_entry #(.COORD_WIDTH(CW), .LOCAL_FRAC_BITS(LOCAL_FRAC_BITS)) u_dy_deta (
    .clk(clk), .ctl(lane_ctl),
    .fa(wmx_r), .da(dyc_r), .fb(wpx_r), .db(dyd_r),
    .entry_r(d_e), .ovf_r(d_ovf)
  );

  // ---- stage 4: determinant cross products ----
  logic signed [PW-1:0] ad_r, bc_r, ad_nxt, bc_nxt;
  logic signed [CW-1:0] a4_r, b4_r, c4_r, d4_r;
  logic                 ovf4_r, ovf4_nxt;

  always_comb begin
    ad_nxt   = PW'(a_e) * PW'(d_e);
    bc_nxt   = PW'(b_e) * PW'(c_e);
    ovf4_nxt = a_ovf | b_ovf | c_ovf | d_ovf;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      ad_r   <= ad_nxt;
      bc_r   <= bc_nxt;
      a4_r   <= a_e;
      b4_r   <= b_e;
      c4_r   <= c_e;
      d4_r   <= d_e;
      ovf4_r <= ovf4_nxt;
    end
  end

  // ---- stage 5: difference, saturate, output word ----
  logic signed [EW-1:0]   diff;
  logic                   det_fits;
  logic signed [DETW-1:0] det_nxt;
  logic [OUT_TW-1:0]      word_nxt;
  logic [OUT_TW-1:0]      out_word_r;

  always_comb begin
    diff     = EW'(ad_r) - EW'(bc_r);
    det_fits = (&diff[EW-1:DETW-1]) | ~(|diff[EW-1:DETW-1]);
    if (det_fits) begin
      det_nxt = diff[DETW-1:0];
    end else if (diff[EW-1]) begin
      det_nxt = DMIN;
    end else begin
      det_nxt = DMAX;
    end
    word_nxt = '0;
    word_nxt[0*CW +: CW]  = a4_r;
    word_nxt[1*CW +: CW]  = b4_r;
    word_nxt[2*CW +: CW]  = c4_r;
    word_nxt[3*CW +: CW]  = d4_r;
    word_nxt[4*CW +: DETW] = det_nxt;
    word_nxt[4*CW+DETW]   = ovf4_r | ~det_fits;
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_word_r <= word_nxt;
    end
  end

  assign out_tdata = out_word_r;

  // ---- checks ----
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !(v1_r | v2_r | v3_r | v4_r | v5_r))
    else $error("stage valid bits not cleared by reset");

  a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r & v2_r & v3_r & v4_r & v5_r))
    else $error("input stalled while a pipeline stage is empty");

  a_entry_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !en4 |=> v3_r && $stable(a_e) && $stable(d_e) && $stable(a_ovf))
    else $error("entry stage lost its word during a stall");

  a_ovf_carry: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && en5 && ovf4_r |=> out_tdata[4*CW+DETW])
    else $error("entry saturation not reported in overflow");

endmodule

`default_nettype wire

// ----- tb/sv/tb_element_jacobian_2d.sv -----
// Self-checking bench for element_jacobian_2d: random and corner-case elements
// are streamed in and each output word is checked against a local predictor.
// Depends on ej2d_pkg and the element_jacobian_2d RTL.
`default_nettype none

module tb_element_jacobian_2d;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW           = 32;
  localparam int LFB          = 14;
  localparam int LW           = LFB + 2;
  localparam int DW           = ej2d_pkg::DET_WIDTH;
  localparam int WW           = 128;  // wide enough for every exact sum
  localparam int IN_W         = ((8*CW + 2*LW + 7)/8)*8;
  localparam int OUT_W        = ((4*CW + DW + 1 + 7)/8)*8;
  localparam int N_RANDOM     = 1800;
  localparam int HOLD_AT      = 600;   // accepted words before the long stall
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 20;

  localparam int MX = 32'h7fffffff;
  localparam int MN = 32'h80000000;
  localparam int U  = 65536;           // 1.0 in Q16.16
  localparam int P1 = 16384;           // 1.0 in Q1.14

  typedef struct packed {
    logic                kind;
    logic [3:0][CW-1:0]  ny;
    logic [3:0][CW-1:0]  nx;
    logic [LW-1:0]       eta;
    logic [LW-1:0]       xi;
  } elem_t;

  typedef struct packed {
    logic [CW-1:0] dx_dxi;
    logic [CW-1:0] dx_deta;
    logic [CW-1:0] dy_dxi;
    logic [CW-1:0] dy_deta;
    logic [DW-1:0] det;
    logic          ovf;
  } jac_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  wire              in_tready;
  // x0, x1, x2, x3, y0, y1, y2, y3, local_xi, local_eta (low to high)
  logic [IN_W-1:0]  in_tdata   = '0;
  // kind
  logic             in_tuser   = 1'b0;
  wire              out_tvalid;
  logic             out_tready = 1'b0;
  // dx_dxi, dx_deta, dy_dxi, dy_deta, determinant, overflow (low to high), pad
  wire [OUT_W-1:0]  out_tdata;

  element_jacobian_2d #(
    .COORD_WIDTH    (CW),
    .LOCAL_FRAC_BITS(LFB)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  elem_t elements_to_send[$];
  jac_t  jacobians_due[$];

  int errors    = 0;
  int in_count  = 0;
  int out_count = 0;
  int n_quad    = 0;
  int n_tri     = 0;
  int n_ovf     = 0;
  bit word_taken = 1'b0;
  bit draining   = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [WW-1:0] clamp_to(input logic signed [WW-1:0] v,
                                                    input int n, inout bit ovf);
    logic signed [WW-1:0] hi, lo;
    hi = 1;
    hi = (hi <<< (n-1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      ovf = 1'b1;
      return hi;
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // (fa*da + fb*db) / (4*one), round half up, saturate to the coordinate format
  function automatic logic [CW-1:0] jac_entry(input logic signed [WW-1:0] fa, da, fb, db,
                                              inout bit ovf);
    logic signed [WW-1:0] s, half;
    half = 1;
    half = half <<< (LFB + 1);
    s = fa*da + fb*db + half;
    s = s >>> (LFB + 2);
    s = clamp_to(s, CW, ovf);
    return s[CW-1:0];
  endfunction

  function automatic jac_t jacobian_of(input elem_t e);
    logic signed [WW-1:0] x[4], y[4];
    logic signed [WW-1:0] one, xi, eta, a, b, c, d, det;
    jac_t j;
    bit   ovf;
    int   i;
    ovf = 1'b0;
    for (i = 0; i < 4; i++) begin
      x[i] = $signed(e.nx[i]);
      y[i] = $signed(e.ny[i]);
    end
    // collapsed triangle: node 3 sits on node 2
    if (!e.kind) begin
      x[3] = x[2];
      y[3] = y[2];
    end
    xi  = $signed(e.xi);
    eta = $signed(e.eta);
    one = 1;
    one = one <<< LFB;
    j.dx_dxi  = jac_entry(one - eta, x[1] - x[0], one + eta, x[2] - x[3], ovf);
    j.dx_deta = jac_entry(one - xi,  x[3] - x[0], one + xi,  x[2] - x[1], ovf);
    j.dy_dxi  = jac_entry(one - eta, y[1] - y[0], one + eta, y[2] - y[3], ovf);
    j.dy_deta = jac_entry(one - xi,  y[3] - y[0], one + xi,  y[2] - y[1], ovf);
    a = $signed(j.dx_dxi);
    b = $signed(j.dx_deta);
    c = $signed(j.dy_dxi);
    d = $signed(j.dy_deta);
    det   = clamp_to(a*d - b*c, DW, ovf);
    j.det = det[DW-1:0];
    j.ovf = ovf;
    return j;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic elem_t mk_elem(input bit kind, input int x0, x1, x2, x3,
                                    input int y0, y1, y2, y3, input int xi, eta);
    elem_t e;
    e.kind  = kind;
    e.nx[0] = x0;  e.nx[1] = x1;  e.nx[2] = x2;  e.nx[3] = x3;
    e.ny[0] = y0;  e.ny[1] = y1;  e.ny[2] = y2;  e.ny[3] = y3;
    e.xi    = xi[LW-1:0];
    e.eta   = eta[LW-1:0];
    return e;
  endfunction

  function automatic int rand_span(input int span);
    return int'($urandom_range(0, 2*span)) - span;
  endfunction

  function automatic elem_t rand_elem();
    elem_t e;
    int    sel, bx, by, span, i;
    sel = $urandom_range(0, 99);
    e.kind = 1'($urandom_range(0, 1));
    if (sel < 50 || sel >= 85) begin
      // plausible element: nodes clustered around a random center
      bx   = rand_span(1 << 22);
      by   = rand_span(1 << 22);
      span = 1 << $urandom_range(4, 21);
      for (i = 0; i < 4; i++) begin
        e.nx[i] = bx + rand_span(span);
        e.ny[i] = by + rand_span(span);
      end
    end else begin
      for (i = 0; i < 4; i++) begin
        e.nx[i] = $urandom;
        e.ny[i] = $urandom;
      end
    end
    if (sel < 85 && !(sel >= 50 && sel < 70)) begin
      e.xi  = LW'(rand_span(P1));
      e.eta = LW'(rand_span(P1));
    end else begin
      // local point anywhere in the 16-bit range, in or out of [-1, 1]
      e.xi  = LW'($urandom);
      e.eta = LW'($urandom);
    end
    return e;
  endfunction

  initial begin
    int i;
    // zero, unit square at center and at both corners
    elements_to_send.push_back(mk_elem(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    elements_to_send.push_back(mk_elem(1, 0, U, U, 0, 0, 0, U, U, 0, 0));
    elements_to_send.push_back(mk_elem(1, 0, U, U, 0, 0, 0, U, U, P1, P1));
    elements_to_send.push_back(mk_elem(1, 0, U, U, 0, 0, 0, U, U, -P1, -P1));
    // clockwise node order gives a negative determinant
    elements_to_send.push_back(mk_elem(1, 0, 0, U, U, 0, U, U, 0, 0, 0));
    // triangles: node 3 carries junk that must not matter
    elements_to_send.push_back(mk_elem(0, 0, U, 0, MX, 0, 0, U, MN, 0, 0));
    elements_to_send.push_back(mk_elem(0, 0, U, 0, MN, 0, 0, U, MX, P1, -P1));
    elements_to_send.push_back(mk_elem(0, MN, MX, MN, 0, MX, MN, MX, 0, 32767, 32767));
    elements_to_send.push_back(mk_elem(0, MX, MN, MX, MN, MN, MX, MN, MX, -32768, -32768));
    // extreme coordinates: some entries saturate
    elements_to_send.push_back(mk_elem(1, MN, MX, MX, MN, MN, MN, MX, MX, 0, 0));
    elements_to_send.push_back(mk_elem(1, MN, MX, MX, MN, MN, MN, MX, MX, -P1, -P1));
    elements_to_send.push_back(mk_elem(1, MX, MN, MN, MX, MX, MX, MN, MN, P1, P1));
    elements_to_send.push_back(mk_elem(1, MX, MX, MX, MX, MX, MX, MX, MX, P1, -P1));
    elements_to_send.push_back(mk_elem(1, MN, MN, MN, MN, MN, MN, MN, MN, -P1, P1));
    // local point outside [-1, 1], both encodable extremes
    elements_to_send.push_back(mk_elem(1, 0, U, U, 0, 0, 0, U, U, 32767, -32768));
    elements_to_send.push_back(mk_elem(1, 0, U, U, 0, 0, 0, U, U, -32768, 32767));
    elements_to_send.push_back(mk_elem(1, MN, MX, MN, MX, MX, MN, MX, MN, -32768, 32767));
    // rounding ties at +0.5 and -0.5 LSB
    elements_to_send.push_back(mk_elem(1, 0, 1, 1, 0, 0, 0, 1, 1, 0, 0));
    elements_to_send.push_back(mk_elem(1, 0, -1, -1, 0, 0, 0, -1, -1, 0, 0));
    elements_to_send.push_back(mk_elem(1, 1, 2, 3, 4, 5, 6, 7, 8, 100, -100));
    for (i = 0; i < N_RANDOM; i++)
      elements_to_send.push_back(rand_elem());

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (elements_to_send.size() > 0 || in_tvalid || jacobians_due.size() > 0)
      @(posedge clk);
    draining = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d elements sent (%0d quads, %0d triangles), %0d results checked,",
             in_count, n_quad, n_tri, out_count);
    $display("%0d of them saturated; %0d mismatches", n_ovf, errors);
    if (errors == 0)
      $display("tb_element_jacobian_2d OK");
    else
      $display("tb_element_jacobian_2d NOT OK");
    $finish;
  end

  initial begin
    #(12.0 * LIMIT_CYCLES);
    $display("tb_element_jacobian_2d NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- driver

  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    logic            nv, nu;
    logic [IN_W-1:0] nd;
    elem_t           e;
    nv = in_tvalid;
    nd = in_tdata;
    nu = in_tuser;
    if (word_taken)
      nv = 1'b0;
    word_taken = 1'b0;
    if (rst_n && !nv) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (elements_to_send.size() > 0) begin
        e  = elements_to_send.pop_front();
        nv = 1'b1;
        nd = {e.eta, e.xi, e.ny, e.nx};
        nu = e.kind;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 20);
          gap_left   = $urandom_range(1, 8);
        end
      end
    end
    in_tvalid <= nv;
    in_tdata  <= nd;
    in_tuser  <= nu;
  end

  // ---------------------------------------------------------------- receiver

  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  mode      = 0;
  int  mode_left = 0;
  int  phase     = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (draining) begin
      out_tready <= 1'b1;
    end else begin
      // one long hold-off so the pipe fills and pushes back on the input
      if (!hold_done && in_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        phase++;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (phase % 3 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic cmp_field(input string name, input logic [63:0] exp_v,
                           input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    elem_t e;
    jac_t  j;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        out_count++;
        if (jacobians_due.size() == 0) begin
          $error("output word with no element outstanding: %h", out_tdata);
          errors++;
        end else begin
          j = jacobians_due.pop_front();
          if (j.ovf)
            n_ovf++;
          cmp_field("dx_dxi",      64'(j.dx_dxi),  64'(out_tdata[0*CW +: CW]));
          cmp_field("dx_deta",     64'(j.dx_deta), 64'(out_tdata[1*CW +: CW]));
          cmp_field("dy_dxi",      64'(j.dy_dxi),  64'(out_tdata[2*CW +: CW]));
          cmp_field("dy_deta",     64'(j.dy_deta), 64'(out_tdata[3*CW +: CW]));
          cmp_field("determinant", j.det,          out_tdata[4*CW +: DW]);
          cmp_field("overflow",    64'(j.ovf),     64'(out_tdata[4*CW+DW]));
          cmp_field("pad",         64'(0),         64'(out_tdata[OUT_W-1:4*CW+DW+1]));
        end
      end
      if (in_tvalid && in_tready) begin
        e.nx   = in_tdata[0 +: 4*CW];
        e.ny   = in_tdata[4*CW +: 4*CW];
        e.xi   = in_tdata[8*CW +: LW];
        e.eta  = in_tdata[8*CW+LW +: LW];
        e.kind = in_tuser;
        jacobians_due.push_back(jacobian_of(e));
        word_taken = 1'b1;
        in_count++;
        if (e.kind)
          n_quad++;
        else
          n_tri++;
      end
    end
  end

endmodule

`default_nettype wire

// ----- element_jacobian_2d.f -----
src/ej2d_pkg.sv
src/ej2d_entry.sv
src/element_jacobian_2d.sv
tb/sv/tb_element_jacobian_2d.sv
